### hw/rtl/sobel_edge_magnitude_stream_unit_macros.svh
// assertion macros of the sobel edge unit, used by its controller
`ifndef SOBEL_EDGE_MAGNITUDE_STREAM_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_STREAM_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define SEM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sem_pkg.sv
// shared constants and control types of the sobel edge unit
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int CFG_BITS       = 11;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;

  // floor(s / 1000) == (s * GRAY_RECIP) >> GRAY_SHIFT for s below 2^18
  localparam logic [18:0] GRAY_RECIP = 19'd268436;
  localparam int          GRAY_SHIFT = 28;
  localparam logic [8:0]  COEF_RED   = 9'd299;
  localparam logic [9:0]  COEF_GREEN = 10'd587;
  localparam logic [6:0]  COEF_BLUE  = 7'd114;

  localparam logic [7:0] EDGE_SAT = 8'd255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic capture;
    logic gray;
    logic div;
    logic shift;
    logic grad;
    logic square;
    logic root_start;
    logic root_take;
    logic drain;
    logic drain_take;
    logic emit;
  } sem_cmd_t;

  typedef struct packed {
    logic drain_pending;
    logic border_hit;
    logic has_result;
    logic interior;
    logic root_done;
    logic out_free;
  } sem_status_t;

endpackage

### hw/rtl/sem_isqrt.sv
// iterative integer square root, one root bit per cycle, saturates at 255
module sem_isqrt import sem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [20:0] value,
  output logic        done,
  output logic [7:0]  root
);

  logic        busy;
  logic [2:0]  step;
  logic        sat;
  logic [15:0] rem;
  logic [15:0] res;
  logic [15:0] bitv;
  logic [16:0] trial;

  assign bitv  = 16'h4000 >> {step, 1'b0};
  assign trial = {1'b0, res} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 3'd7);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= (value[20:16] != '0);
      rem <= value[15:0];
      res <= '0;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= 16'({1'b0, rem} - trial);
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
    end
  end

  assign root = sat ? EDGE_SAT : res[7:0];

endmodule

### hw/rtl/sem_ctrl.sv
// sequencing state machine of the sobel edge unit
`include "sobel_edge_magnitude_stream_unit_macros.svh"

module sem_ctrl import sem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_opcode,
  output logic        in_ready,
  input  sem_status_t st,
  output sem_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_GRAY   = 11'b00000000010,
    S_DIV    = 11'b00000000100,
    S_SHIFT  = 11'b00000001000,
    S_GRAD   = 11'b00000010000,
    S_SQ     = 11'b00000100000,
    S_RSTART = 11'b00001000000,
    S_ROOT   = 11'b00010000000,
    S_DRAIN  = 11'b00100000000,
    S_DRD    = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_opcode == OP_DRAIN) ? S_DRAIN : S_GRAY;
        end
      end
      S_GRAY:  state_next = S_DIV;
      S_DIV:   state_next = S_SHIFT;
      S_SHIFT: begin
        if (st.border_hit) begin
          state_next = S_EMIT;
        end else if (st.has_result && st.interior) begin
          state_next = S_GRAD;
        end else if (st.has_result) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_GRAD:   state_next = S_SQ;
      S_SQ:     state_next = S_RSTART;
      S_RSTART: state_next = S_ROOT;
      S_ROOT: begin
        if (st.root_done) begin
          state_next = S_EMIT;
        end
      end
      S_DRAIN: state_next = st.drain_pending ? S_DRD : S_IDLE;
      S_DRD:   state_next = S_EMIT;
      S_EMIT: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.gray       = (state == S_GRAY);
    cmd.div        = (state == S_DIV);
    cmd.shift      = (state == S_SHIFT);
    cmd.grad       = (state == S_GRAD);
    cmd.square     = (state == S_SQ);
    cmd.root_start = (state == S_RSTART);
    cmd.root_take  = (state == S_ROOT) && st.root_done;
    cmd.drain      = (state == S_DRAIN);
    cmd.drain_take = (state == S_DRD);
    cmd.emit       = (state == S_EMIT);
  end

  `SEM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, (state == S_IDLE) && in_valid, state != S_IDLE, "accepted transaction left the controller idle")
  `SEM_ASSERT_NEXT(a_root_to_emit, clk, rst, (state == S_ROOT) && st.root_done, state == S_EMIT, "square root finished without emitting")
  `SEM_ASSERT_NEXT(a_empty_drain_idle, clk, rst, (state == S_DRAIN) && !st.drain_pending, state == S_IDLE, "drain with nothing pending produced work")

endmodule

### hw/rtl/sem_dp.sv
// datapath: gray conversion, line buffers, 3x3 window, gradient and output register
module sem_dp import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sem_cmd_t            cmd,
  output sem_status_t         st,
  input  logic [23:0]         pix_data,
  input  logic [CFG_BITS-1:0] cfg_width,
  input  logic [CFG_BITS-1:0] cfg_height,
  input  logic                restart,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_value,
  output logic                out_done
);

  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [7:0]  older_mem [MAX_WIDTH];
  logic [7:0]  newer_mem [MAX_WIDTH];
  logic [7:0]  older_rdata, newer_rdata, older_x;
  logic [CW-1:0] older_addr, newer_addr;
  logic        older_rd, newer_rd;

  logic [7:0]  red, green, blue;
  logic [17:0] wsum;
  logic [36:0] wprod;
  logic [7:0]  gray;
  logic [7:0]  taps [3][3];
  logic signed [10:0] gx, gy;
  logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [21:0] gx_sq, gy_sq;
  logic [20:0] sq_sum;
  logic [7:0]  root;
  logic        root_done;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [LW-1:0] drain_pos;
  logic          drain_pending;
  logic          drain_old, drain_last;

  logic [LW-1:0] used_w;
  logic [HW-1:0] used_h;
  logic          h2;
  logic [LW:0]   drain_total;
  logic          drain_end;
  logic [CW-1:0] drain_idx;
  logic          col_end, row_end;

  logic [7:0]  res_val;
  logic        res_done;
  logic        out_free;

  always_comb begin
    if (cfg_width == '0) begin
      used_w = LW'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      used_w = LW'(MAX_WIDTH);
    end else begin
      used_w = LW'(cfg_width);
    end
    if (cfg_height == '0) begin
      used_h = HW'(1);
    end else if (int'(cfg_height) > MAX_HEIGHT) begin
      used_h = HW'(MAX_HEIGHT);
    end else begin
      used_h = HW'(cfg_height);
    end
  end

  assign h2          = (used_h >= HW'(2));
  assign drain_total = h2 ? ((LW+1)'(used_w) + (LW+1)'(1)) : (LW+1)'(used_w);
  assign drain_end   = ((LW+1)'(drain_pos) + (LW+1)'(1)) >= drain_total;
  assign drain_idx   = h2 ? CW'(drain_pos - LW'(1)) : CW'(drain_pos);
  assign col_end     = ((LW+1)'(col) + (LW+1)'(1)) >= (LW+1)'(used_w);
  assign row_end     = ((HW+1)'(row) + (HW+1)'(1)) >= (HW+1)'(used_h);

  assign out_free = !out_valid || out_ready;

  assign st.drain_pending = drain_pending;
  assign st.border_hit    = (col == '0) && (row >= RW'(2));
  assign st.has_result    = (col != '0) && (row != '0);
  assign st.interior      = (col >= CW'(2)) && (row >= RW'(2));
  assign st.root_done     = root_done;
  assign st.out_free      = out_free;

  // line buffer ports
  assign older_rd   = cmd.gray || cmd.div || cmd.drain;
  assign newer_rd   = cmd.gray || cmd.drain;
  assign older_addr = cmd.gray ? col : CW'(used_w - LW'(1));
  assign newer_addr = cmd.gray ? col : drain_idx;

  always_ff @(posedge clk) begin
    if (older_rd) begin
      older_rdata <= older_mem[older_addr];
    end
    if (newer_rd) begin
      newer_rdata <= newer_mem[newer_addr];
    end
    if (cmd.shift) begin
      older_mem[col] <= newer_rdata;
      newer_mem[col] <= gray;
    end
  end

  // gray conversion
  assign wprod = 37'(wsum) * 37'(GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      red   <= pix_data[7:0];
      green <= pix_data[15:8];
      blue  <= pix_data[23:16];
    end
    if (cmd.gray) begin
      wsum <= 18'(red) * 18'(COEF_RED) + 18'(green) * 18'(COEF_GREEN)
            + 18'(blue) * 18'(COEF_BLUE);
    end
    if (cmd.div) begin
      gray    <= wprod[GRAY_SHIFT +: 8];
      older_x <= older_rdata;
    end
  end

  // window and gradient
  assign gx_pos = {2'b0, taps[0][2]} + {1'b0, taps[1][2], 1'b0} + {2'b0, taps[2][2]};
  assign gx_neg = {2'b0, taps[0][0]} + {1'b0, taps[1][0], 1'b0} + {2'b0, taps[2][0]};
  assign gy_pos = {2'b0, taps[2][0]} + {1'b0, taps[2][1], 1'b0} + {2'b0, taps[2][2]};
  assign gy_neg = {2'b0, taps[0][0]} + {1'b0, taps[0][1], 1'b0} + {2'b0, taps[0][2]};
  assign gx_sq  = gx * gx;
  assign gy_sq  = gy * gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          taps[r][c] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        taps[r][0] <= taps[r][1];
        taps[r][1] <= taps[r][2];
      end
      taps[0][2] <= older_x;
      taps[1][2] <= newer_rdata;
      taps[2][2] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end
    if (cmd.square) begin
      sq_sum <= 21'(gx_sq) + 21'(gy_sq);
    end
  end

  sem_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .value (sq_sum),
    .done  (root_done),
    .root  (root)
  );

  // position counters and drain bookkeeping
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col           <= '0;
      row           <= '0;
      drain_pos     <= '0;
      drain_pending <= 1'b0;
    end else if (cmd.shift) begin
      if ((col == '0) && (row == '0)) begin
        drain_pending <= 1'b0;
        drain_pos     <= '0;
      end
      if (col_end) begin
        col <= '0;
        if (row_end) begin
          row           <= '0;
          drain_pending <= 1'b1;
          drain_pos     <= '0;
        end else begin
          row <= row + RW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end else if (cmd.drain && drain_pending) begin
      if (drain_end) begin
        drain_pending <= 1'b0;
        drain_pos     <= '0;
      end else begin
        drain_pos <= drain_pos + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      drain_old  <= h2 && (drain_pos == '0);
      drain_last <= drain_end;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      // plain border pixel reads the center tap, which is the incoming middle tap
      res_val  <= st.border_hit ? older_rdata : taps[1][2];
      res_done <= 1'b0;
    end else if (cmd.root_take) begin
      res_val  <= root;
      res_done <= 1'b0;
    end else if (cmd.drain_take) begin
      res_val  <= drain_old ? older_rdata : newer_rdata;
      res_done <= drain_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      out_value <= res_val;
      out_done  <= res_done;
    end
  end

endmodule

### hw/rtl/sobel_edge_magnitude_stream_unit.sv
// top level of the sobel edge magnitude stream unit
// usage:
//   s_* carries one transaction per item: s_tuser selects pixel or drain, s_tdata the pixel.
//   m_* carries results: m_tdata is the edge value, m_tuser marks the frame's last pixel,
//   m_tlast is high on every result since an item causes at most one.
//   results trail their pixel by one row and one pixel; the last row plus one pixel of a
//   frame (only the row in a one-row frame) comes out through drain items, one result each.
//   the apb port holds frame_width at 0x0 and frame_height at 0x4; a write restarts the frame.
// sequencing:
//   one item at a time. a pixel passes gray, divide and shift, then idles with no result,
//   emits a border result, or runs gradient, square and the 8-step square root unit before
//   emitting. a drain emits only if a result is pending. line buffers are written once per pixel.
//   a finished result sits in the output register while the next item is accepted.
// reset:
//   rst clears position counters, drain state and window; line buffer contents are
//   unspecified until written. a stalled receiver holds the unit in its emit step.
module sobel_edge_magnitude_stream_unit import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // edge_value
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;
  logic                cfg_write;
  sem_cmd_t            cmd;
  sem_status_t         st;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_WIDTH:  frame_width  <= pwdata[CFG_BITS-1:0];
        REG_HEIGHT: frame_height <= pwdata[CFG_BITS-1:0];
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {21'b0, frame_height} : {21'b0, frame_width};

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_opcode (s_tuser[0]),
    .in_ready  (s_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sem_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .pix_data   (s_tdata),
    .cfg_width  (frame_width),
    .cfg_height (frame_height),
    .restart    (cfg_write),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (m_tdata),
    .out_done   (m_tuser[0])
  );

  assign m_tlast = 1'b1;

endmodule

### tb/sv/tb_sobel_edge_magnitude_stream_unit.sv
// testbench of the sobel edge magnitude stream unit: directed and random frames, checked per result
`timescale 1ns / 1ps
module tb_sobel_edge_magnitude_stream_unit;
  import sem_pkg::*;

  typedef struct {
    logic [7:0] edge_val;
    logic       last;
    logic       done;
  } edge_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = OP_PIXEL;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sobel_edge_magnitude_stream_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  older_line [MAX_WIDTH_DEF];
  logic [7:0]  newer_line [MAX_WIDTH_DEF];
  logic [7:0]  win [3][3];
  logic [10:0] width_reg, height_reg;
  int          col_pos, row_pos, drain_idx;
  bit          drain_armed;
  edge_result_t edge_q[$];
  int          errors = 0;

  // stimulus control
  int burst_left = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_cycles = 0;
  int rx_phase = 0;
  int pixels_sent = 0;

  function automatic int eff_size(logic [10:0] v, int max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return int'(v);
  endfunction

  function automatic int root_floor(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic logic [7:0] sobel_mag();
    int gx, gy, sum;
    gx = win[0][2] + 2 * win[1][2] + win[2][2] - win[0][0] - 2 * win[1][0] - win[2][0];
    gy = win[2][0] + 2 * win[2][1] + win[2][2] - win[0][0] - 2 * win[0][1] - win[0][2];
    sum = gx * gx + gy * gy;
    if (sum >= 65536) return EDGE_SAT;
    return 8'(root_floor(sum));
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    drain_idx = 0;
    drain_armed = 1'b0;
  endfunction

  function automatic void push_edge(logic [7:0] v, logic done);
    edge_result_t r;
    r.edge_val = v;
    r.last = 1'b1;
    r.done = done;
    edge_q.push_back(r);
  endfunction

  function automatic void predict_edge(logic [0:0] op, logic [23:0] px);
    int w, h, total, gray, x, pr, pc;
    logic [7:0] v;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    if (op == OP_DRAIN) begin
      if (!drain_armed) return;
      total = (h >= 2) ? w + 1 : w;
      if (h >= 2) v = (drain_idx == 0) ? older_line[w - 1] : newer_line[drain_idx - 1];
      else v = newer_line[drain_idx];
      drain_idx++;
      if (drain_idx >= total) begin
        drain_armed = 1'b0;
        drain_idx = 0;
        push_edge(v, 1'b1);
      end else begin
        push_edge(v, 1'b0);
      end
      return;
    end
    if (row_pos == 0 && col_pos == 0) begin
      drain_armed = 1'b0;
      drain_idx = 0;
    end
    gray = (COEF_RED * px[7:0] + COEF_GREEN * px[15:8] + COEF_BLUE * px[23:16]) / 1000;
    // last column two rows up is emitted when a new row begins
    if (col_pos == 0 && row_pos >= 2) push_edge(older_line[w - 1], 1'b0);
    x = col_pos;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = older_line[x];
    win[1][2] = newer_line[x];
    win[2][2] = 8'(gray);
    older_line[x] = newer_line[x];
    newer_line[x] = 8'(gray);
    if (col_pos >= 1 && row_pos >= 1) begin
      pr = row_pos - 1;
      pc = col_pos - 1;
      if (pr >= 1 && pr + 2 <= h && pc >= 1 && pc + 2 <= w) push_edge(sobel_mag(), 1'b0);
      else push_edge(win[1][1], 1'b0);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        drain_armed = 1'b1;
        drain_idx = 0;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  // result checking, then prediction of the accepted item
  always @(posedge clk) begin
    edge_result_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (edge_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, -1);
        end else begin
          e = edge_q.pop_front();
          if (m_tdata !== e.edge_val) report_mismatch("edge_value", m_tdata, e.edge_val);
          if (m_tlast !== e.last) report_mismatch("last_in_run", m_tlast, e.last);
          if (m_tuser[0] !== e.done) report_mismatch("frame_done", m_tuser, e.done);
        end
      end
      if (s_tvalid && s_tready) predict_edge(s_tuser, s_tdata);
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else if (rx_steady) begin
      m_tready <= 1'b1;
    end else if (rx_phase == 0) begin
      rx_phase = $urandom_range(1, 12);
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      rx_phase--;
    end
  end

  task automatic send_item(logic [0:0] op, logic [23:0] px);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= px;
    if (op == OP_PIXEL) pixels_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (edge_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_WIDTH) width_reg = val[10:0];
    else height_reg = val[10:0];
    restart_frame();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_frame(int w, int h);
    reg_write(REG_WIDTH, {21'($urandom_range(0, 2097151)), w[10:0]});
    reg_write(REG_HEIGHT, {21'($urandom_range(0, 2097151)), h[10:0]});
  endtask

  function automatic logic [23:0] pick_pixel(int style, int base);
    if (style == 0) return 24'($urandom);
    return {8'(base + $urandom_range(0, 24)), 8'(base + $urandom_range(0, 24)),
            8'(base + $urandom_range(0, 24))};
  endfunction

  task automatic send_frame(int w, int h, int style, int drains);
    int base;
    base = $urandom_range(0, 230);
    for (int i = 0; i < w * h; i++) begin
      if (style == 1 && $urandom_range(0, 7) == 0) base = $urandom_range(0, 230);
      send_item(OP_PIXEL, pick_pixel(style, base));
    end
    repeat (drains) send_item(OP_DRAIN, 24'($urandom));
  endtask

  task automatic test_reset_defaults();
    // 640x480 after reset: first row pixels give nothing
    repeat (3) send_item(OP_PIXEL, 24'($urandom));
    send_item(OP_DRAIN, 24'($urandom));
    wait_results();
  endtask

  task automatic test_small_frame_extremes();
    set_frame(3, 3);
    send_item(OP_PIXEL, 24'h000000);
    send_item(OP_PIXEL, 24'hffffff);
    send_item(OP_PIXEL, 24'h0000ff);
    send_item(OP_PIXEL, 24'h00ff00);
    send_item(OP_PIXEL, 24'hff0000);
    send_item(OP_PIXEL, 24'h808080);
    send_item(OP_PIXEL, 24'hffffff);
    send_item(OP_PIXEL, 24'h000000);
    send_item(OP_PIXEL, 24'h7f7f7f);
    repeat (4) send_item(OP_DRAIN, 24'hffffff);
    // drain with nothing pending
    send_item(OP_DRAIN, 24'h000000);
    // step edge saturates the magnitude
    for (int i = 0; i < 9; i++)
      send_item(OP_PIXEL, (i % 3 == 2) ? 24'hffffff : 24'h000000);
    repeat (2) send_item(OP_DRAIN, 24'h0);
    // new frame drops the two pending drain results
    repeat (3) send_item(OP_PIXEL, 24'($urandom));
    send_item(OP_DRAIN, 24'h0);
    wait_results();
  endtask

  task automatic test_tiny_frames();
    set_frame(0, 0);
    send_frame(1, 1, 0, 2);
    wait_results();
    set_frame(2, 2);
    send_frame(2, 2, 0, 3);
    wait_results();
    set_frame(1, 4);
    send_frame(1, 4, 0, 2);
    wait_results();
    set_frame(5, 1);
    send_frame(5, 1, 0, 5);
    wait_results();
  endtask

  task automatic test_output_hold_off();
    set_frame(8, 6);
    tx_steady = 1'b1;
    hold_cycles = 300;
    send_frame(8, 6, 1, 9);
    tx_steady = 1'b0;
    wait_results();
  endtask

  task automatic test_random_frames();
    int w, h, sel, total, drains, start;
    start = pixels_sent;
    while (pixels_sent - start < 700) begin
      sel = $urandom_range(0, 9);
      w = (sel < 8) ? $urandom_range(3, 10) : (sel == 8) ? $urandom_range(1, 2)
                                                        : $urandom_range(11, 40);
      sel = $urandom_range(0, 9);
      h = (sel < 8) ? $urandom_range(3, 8) : $urandom_range(1, 2);
      rx_steady = ($urandom_range(0, 4) == 0);
      set_frame(w, h);
      total = (h >= 2) ? w + 1 : w;
      sel = $urandom_range(0, 9);
      drains = (sel < 7) ? total : (sel < 9) ? $urandom_range(0, total) : total + 2;
      send_frame(w, h, $urandom_range(0, 1), drains);
      // sometimes a second frame at the same setting, dropping what was left
      if ($urandom_range(0, 3) == 0) send_frame(w, h, $urandom_range(0, 1), total);
      // sometimes a frame cut short by a register write
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, w * h)) send_item(OP_PIXEL, 24'($urandom));
      end
      wait_results();
    end
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_frame();
    for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
    test_reset_defaults();
    test_small_frame_extremes();
    test_tiny_frames();
    test_output_hold_off();
    test_random_frames();
    wait_results();
    if (edge_q.size() != 0) report_mismatch("results left over", 0, edge_q.size());
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
